@@ rtl/core/arc_pkg.sv @@
`timescale 1ns / 1ps

package arc_pkg;

   // List codes held by every directory cell.
   localparam logic [2:0] LIST_FREE = 3'd0;
   localparam logic [2:0] LIST_T1   = 3'd1;
   localparam logic [2:0] LIST_T2   = 3'd2;
   localparam logic [2:0] LIST_B1   = 3'd3;
   localparam logic [2:0] LIST_B2   = 3'd4;
   localparam int unsigned LIST_NUM = 5;

   // Result status codes.
   localparam int unsigned STATUS_W = 3;
   localparam logic [STATUS_W-1:0] STATUS_HIT_T1   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIT_T2   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_GET_MISS = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_PUT_NEW  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_PUT_B1   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_PUT_B2   = 3'd5;

   // Transaction kinds.
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // Field widths fixed by the interface.
   localparam int unsigned CAP_W   = 7;
   localparam int unsigned EVKEY_W = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Operation broadcast to the row of cells.
   typedef enum logic [1:0] {
      OP_NOP,
      OP_FIND,
      OP_PICK,
      OP_MOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [2:0]  list_from;
      logic [2:0]  list_to;
      logic        write_key;
   } cell_cmd_type;

endpackage

@@ rtl/core/arc_if.sv @@
`timescale 1ns / 1ps

// Request channel: one lookup or insertion.
interface arc_req_if #(parameter int KEY_WIDTH = 32);
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [KEY_WIDTH-1:0] key;

   modport source (output valid, kind, key, input ready);
   modport sink (input valid, kind, key, output ready);
endinterface

// Response channel: status and the evicted resident key.
interface arc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        evict_valid;
   logic [31:0] evict_key;

   modport source (output valid, status, evict_valid, evict_key, input ready);
   modport sink (input valid, status, evict_valid, evict_key, output ready);
endinterface

// Configuration channel: the capacity register.
interface arc_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/arc_replacement_policy.sv @@
`timescale 1ns / 1ps

// ARC replacement directory.
// req_chan carries one transaction: kind (get or put after miss) and key.
// rsp_chan returns exactly one transaction per request: status, and the
// resident key evicted by it, if any. csr_chan writes the capacity register;
// it is always ready, and it is to be written only while the block is idle;
// the block itself does not enforce this. The directory is a row of
// 2*MAX_ENTRIES cells, each holding one key, its list and its age. Every step
// broadcasts one command to all cells and reads the selected cell back in the
// following cycle. The work of a put of a new key is set by how many ghost
// drops and demotions it needs. A ghost put always runs the fixed-point
// division of the ghost counts, one quotient bit per cycle, and skips the
// demotion when no resident key is left to demote. The result becomes
// visible in the same cycle that the next request can be accepted. If the
// receiver stalls, the result holds in the output register; the block
// goes on, and waits in its output state only when its next result is
// ready while the old one is still held.
// Synchronous reset puts every cell on the free list, clears target p and
// sets capacity to 64; the block accepts requests in the cycle after reset.
module arc_replacement_policy
   import arc_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int KEY_WIDTH   = 32,
   parameter int P_FRAC_BITS = 8
) (
   input logic clock,
   input logic reset,
   arc_req_if.sink   req_chan,
   arc_rsp_if.source rsp_chan,
   arc_csr_if.sink   csr_chan
);

   localparam int SLOTS = 2 * MAX_ENTRIES;
   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int PW    = CW + P_FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE,
      S_WAIT,
      S_CLASS,
      S_DIV,
      S_ADAPT,
      S_DEMOTE,
      S_DEM_MV,
      S_REFIND,
      S_REFIND_MV,
      S_NEW,
      S_DROP_MV,
      S_EVT1_MV,
      S_FREE,
      S_TAKE,
      S_TAKE_MV,
      S_OUT
   } state_type;

   state_type      st_ff;
   state_type      ret_ff;
   state_type      cont_ff;
   state_type      drop_ff;
   logic           kind_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic           ev_ff;
   logic [KEY_WIDTH-1:0] ek_ff;
   logic           b2hit_ff;
   logic [2:0]     dl_ff;
   logic [CW-1:0]  cnt_ff [LIST_NUM];
   logic [PW-1:0]  p_ff;
   logic [CAP_W-1:0] cap_ff;
   cell_cmd_type   cmd_ff;
   logic [KEY_WIDTH-1:0] cmd_key_ff;
   logic [AW-1:0]  cmd_age_ff;
   logic           div_start_ff;
   logic [CW-1:0]  div_num_ff;
   logic [CW-1:0]  div_den_ff;
   logic           rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic           rsp_ev_ff;
   logic [EVKEY_W-1:0]  rsp_ek_ff;

   logic           red_hit;
   logic [2:0]     red_list;
   logic [AW-1:0]  red_age;
   logic [KEY_WIDTH-1:0] red_key;
   logic           div_done;
   logic [PW-1:0]  div_quo;

   logic [CW-1:0]  cap_c;
   logic [PW-1:0]  cap_f;
   logic [PW-1:0]  t1_f;
   logic           from_t1;
   logic [2:0]     dem_pref;
   logic [2:0]     dem_alt;
   logic [2:0]     dem_l;
   logic           dem_none;
   logic [CW:0]    t1b1;
   logic [CW+1:0]  all_n;
   logic [CW:0]    cap_2;
   logic [PW:0]    p_sum;

   // Clamped capacity and the demotion choice.
   always_comb begin
      if (cap_ff == '0) begin
         cap_c = CW'(1);
      end else if (cap_ff > MAX_ENTRIES) begin
         cap_c = CW'(MAX_ENTRIES);
      end else begin
         cap_c = CW'(cap_ff);
      end
      cap_f    = PW'(cap_c) << P_FRAC_BITS;
      t1_f     = PW'(cnt_ff[LIST_T1]) << P_FRAC_BITS;
      from_t1  = (cnt_ff[LIST_T1] != '0) && ((t1_f > p_ff) || b2hit_ff);
      dem_pref = from_t1 ? LIST_T1 : LIST_T2;
      dem_alt  = from_t1 ? LIST_T2 : LIST_T1;
      dem_l    = (cnt_ff[dem_pref] != '0) ? dem_pref : dem_alt;
      dem_none = (cnt_ff[LIST_T1] == '0) && (cnt_ff[LIST_T2] == '0);
      t1b1     = (CW+1)'(cnt_ff[LIST_T1]) + (CW+1)'(cnt_ff[LIST_B1]);
      all_n    = (CW+2)'(cnt_ff[LIST_T1]) + (CW+2)'(cnt_ff[LIST_T2])
               + (CW+2)'(cnt_ff[LIST_B1]) + (CW+2)'(cnt_ff[LIST_B2]);
      cap_2    = (CW+1)'(cap_c) << 1;
      p_sum    = (PW+1)'(p_ff) + (PW+1)'(div_quo);
   end

   arc_cell_array #(
      .SLOTS (SLOTS),
      .KW    (KEY_WIDTH),
      .AW    (AW)
   ) u_cells (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_ff),
      .cmd_key  (cmd_key_ff),
      .cmd_age  (cmd_age_ff),
      .red_hit  (red_hit),
      .red_list (red_list),
      .red_age  (red_age),
      .red_key  (red_key)
   );

   arc_div #(
      .NW   (CW),
      .FRAC (P_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sequencer: issues cell commands, tracks list sizes and target p.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         ret_ff       <= S_IDLE;
         cont_ff      <= S_IDLE;
         drop_ff      <= S_IDLE;
         cmd_ff       <= '{op: OP_NOP, list_from: LIST_FREE, list_to: LIST_FREE,
                           write_key: 1'b0};
         div_start_ff <= 1'b0;
         p_ff         <= '0;
         cap_ff       <= CAP_RESET;
         b2hit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LIST_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
         cnt_ff[LIST_FREE] <= CW'(SLOTS);
      end else begin
         cmd_ff.op    <= OP_NOP;
         div_start_ff <= 1'b0;

         if (csr_chan.valid) begin
            cap_ff <= csr_chan.data;
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (st_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  kind_ff           <= req_chan.kind;
                  key_ff            <= req_chan.key;
                  ev_ff             <= 1'b0;
                  ek_ff             <= '0;
                  b2hit_ff          <= 1'b0;
                  cmd_ff.op         <= OP_FIND;
                  cmd_key_ff        <= req_chan.key;
                  ret_ff            <= S_CLASS;
                  st_ff             <= S_WAIT;
               end
            end
            S_WAIT: begin
               st_ff <= ret_ff;
            end
            S_CLASS: begin
               if (red_hit && (red_list == LIST_T1 || red_list == LIST_T2)) begin
                  status_ff         <= (red_list == LIST_T1) ? STATUS_HIT_T1
                                                             : STATUS_HIT_T2;
                  cmd_ff.op         <= OP_MOVE;
                  cmd_ff.list_from  <= red_list;
                  cmd_ff.list_to    <= LIST_T2;
                  cmd_ff.write_key  <= 1'b0;
                  cmd_age_ff        <= red_age;
                  if (red_list != LIST_T2) begin
                     cnt_ff[red_list] <= cnt_ff[red_list] - CW'(1);
                     cnt_ff[LIST_T2]  <= cnt_ff[LIST_T2] + CW'(1);
                  end
                  ret_ff <= S_OUT;
                  st_ff  <= S_WAIT;
               end else if (kind_ff == KIND_GET) begin
                  status_ff <= STATUS_GET_MISS;
                  st_ff     <= S_OUT;
               end else if (red_hit && red_list == LIST_B1) begin
                  status_ff    <= STATUS_PUT_B1;
                  div_num_ff   <= cnt_ff[LIST_B2];
                  div_den_ff   <= cnt_ff[LIST_B1];
                  div_start_ff <= 1'b1;
                  st_ff        <= S_DIV;
               end else if (red_hit && red_list == LIST_B2) begin
                  status_ff    <= STATUS_PUT_B2;
                  b2hit_ff     <= 1'b1;
                  div_num_ff   <= cnt_ff[LIST_B1];
                  div_den_ff   <= cnt_ff[LIST_B2];
                  div_start_ff <= 1'b1;
                  st_ff        <= S_DIV;
               end else begin
                  status_ff <= STATUS_PUT_NEW;
                  st_ff     <= S_NEW;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  st_ff <= S_ADAPT;
               end
            end
            S_ADAPT: begin
               // A ratio of one applies when the hit list is the larger.
               if (!b2hit_ff) begin
                  if (cnt_ff[LIST_B1] >= cnt_ff[LIST_B2]) begin
                     p_ff <= ((PW+1)'(p_ff) + (PW+1)'(PW'(1) << P_FRAC_BITS)
                              > (PW+1)'(cap_f)) ? cap_f : p_ff + (PW'(1) << P_FRAC_BITS);
                  end else begin
                     p_ff <= (p_sum > (PW+1)'(cap_f)) ? cap_f : PW'(p_sum);
                  end
               end else begin
                  if (cnt_ff[LIST_B2] >= cnt_ff[LIST_B1]) begin
                     p_ff <= (p_ff > (PW'(1) << P_FRAC_BITS))
                           ? p_ff - (PW'(1) << P_FRAC_BITS) : '0;
                  end else begin
                     p_ff <= (p_ff > div_quo) ? p_ff - div_quo : '0;
                  end
               end
               cont_ff <= S_REFIND;
               st_ff   <= S_DEMOTE;
            end
            S_DEMOTE: begin
               if (dem_none) begin
                  st_ff <= cont_ff;
               end else begin
                  dl_ff            <= dem_l;
                  cmd_ff.op        <= OP_PICK;
                  cmd_ff.list_from <= dem_l;
                  cmd_age_ff       <= AW'(cnt_ff[dem_l] - CW'(1));
                  ret_ff           <= S_DEM_MV;
                  st_ff            <= S_WAIT;
               end
            end
            S_DEM_MV: begin
               ev_ff            <= 1'b1;
               ek_ff            <= red_key;
               cmd_ff.op        <= OP_MOVE;
               cmd_ff.list_from <= dl_ff;
               cmd_ff.list_to   <= (dl_ff == LIST_T1) ? LIST_B1 : LIST_B2;
               cmd_ff.write_key <= 1'b0;
               cmd_age_ff       <= red_age;
               cnt_ff[dl_ff]    <= cnt_ff[dl_ff] - CW'(1);
               if (dl_ff == LIST_T1) begin
                  cnt_ff[LIST_B1] <= cnt_ff[LIST_B1] + CW'(1);
               end else begin
                  cnt_ff[LIST_B2] <= cnt_ff[LIST_B2] + CW'(1);
               end
               ret_ff <= cont_ff;
               st_ff  <= S_WAIT;
            end
            S_REFIND: begin
               // The ghost may have aged during demotion; look it up again.
               cmd_ff.op  <= OP_FIND;
               cmd_key_ff <= key_ff;
               ret_ff     <= S_REFIND_MV;
               st_ff      <= S_WAIT;
            end
            S_REFIND_MV: begin
               cmd_ff.op         <= OP_MOVE;
               cmd_ff.list_from  <= red_list;
               cmd_ff.list_to    <= LIST_T2;
               cmd_ff.write_key  <= 1'b0;
               cmd_age_ff        <= red_age;
               cnt_ff[red_list]  <= cnt_ff[red_list] - CW'(1);
               cnt_ff[LIST_T2]   <= cnt_ff[LIST_T2] + CW'(1);
               ret_ff            <= S_OUT;
               st_ff             <= S_WAIT;
            end
            S_NEW: begin
               cont_ff <= S_FREE;
               if (t1b1 >= (CW+1)'(cap_c)) begin
                  if (cnt_ff[LIST_T1] < cap_c) begin
                     if (cnt_ff[LIST_B1] != '0) begin
                        cmd_ff.op        <= OP_PICK;
                        cmd_ff.list_from <= LIST_B1;
                        cmd_age_ff       <= AW'(cnt_ff[LIST_B1] - CW'(1));
                        drop_ff          <= S_DEMOTE;
                        ret_ff           <= S_DROP_MV;
                        st_ff            <= S_WAIT;
                     end else begin
                        st_ff <= S_DEMOTE;
                     end
                  end else if (cnt_ff[LIST_T1] != '0) begin
                     cmd_ff.op        <= OP_PICK;
                     cmd_ff.list_from <= LIST_T1;
                     cmd_age_ff       <= AW'(cnt_ff[LIST_T1] - CW'(1));
                     ret_ff           <= S_EVT1_MV;
                     st_ff            <= S_WAIT;
                  end else begin
                     st_ff <= S_FREE;
                  end
               end else if (all_n >= (CW+2)'(cap_c)) begin
                  if (all_n >= (CW+2)'(cap_2) && cnt_ff[LIST_B2] != '0) begin
                     cmd_ff.op        <= OP_PICK;
                     cmd_ff.list_from <= LIST_B2;
                     cmd_age_ff       <= AW'(cnt_ff[LIST_B2] - CW'(1));
                     drop_ff          <= S_DEMOTE;
                     ret_ff           <= S_DROP_MV;
                     st_ff            <= S_WAIT;
                  end else begin
                     st_ff <= S_DEMOTE;
                  end
               end else begin
                  st_ff <= S_FREE;
               end
            end
            S_DROP_MV: begin
               // Ghost dropped silently onto the free list.
               cmd_ff.op         <= OP_MOVE;
               cmd_ff.list_from  <= red_list;
               cmd_ff.list_to    <= LIST_FREE;
               cmd_ff.write_key  <= 1'b0;
               cmd_age_ff        <= red_age;
               cnt_ff[red_list]  <= cnt_ff[red_list] - CW'(1);
               cnt_ff[LIST_FREE] <= cnt_ff[LIST_FREE] + CW'(1);
               ret_ff            <= drop_ff;
               st_ff             <= S_WAIT;
            end
            S_EVT1_MV: begin
               ev_ff             <= 1'b1;
               ek_ff             <= red_key;
               cmd_ff.op         <= OP_MOVE;
               cmd_ff.list_from  <= LIST_T1;
               cmd_ff.list_to    <= LIST_FREE;
               cmd_ff.write_key  <= 1'b0;
               cmd_age_ff        <= red_age;
               cnt_ff[LIST_T1]   <= cnt_ff[LIST_T1] - CW'(1);
               cnt_ff[LIST_FREE] <= cnt_ff[LIST_FREE] + CW'(1);
               ret_ff            <= S_FREE;
               st_ff             <= S_WAIT;
            end
            S_FREE: begin
               if (cnt_ff[LIST_FREE] != '0) begin
                  st_ff <= S_TAKE;
               end else if (cnt_ff[LIST_B2] != '0) begin
                  cmd_ff.op        <= OP_PICK;
                  cmd_ff.list_from <= LIST_B2;
                  cmd_age_ff       <= AW'(cnt_ff[LIST_B2] - CW'(1));
                  drop_ff          <= S_TAKE;
                  ret_ff           <= S_DROP_MV;
                  st_ff            <= S_WAIT;
               end else if (cnt_ff[LIST_B1] != '0) begin
                  cmd_ff.op        <= OP_PICK;
                  cmd_ff.list_from <= LIST_B1;
                  cmd_age_ff       <= AW'(cnt_ff[LIST_B1] - CW'(1));
                  drop_ff          <= S_TAKE;
                  ret_ff           <= S_DROP_MV;
                  st_ff            <= S_WAIT;
               end else begin
                  st_ff <= S_OUT;
               end
            end
            S_TAKE: begin
               cmd_ff.op        <= OP_PICK;
               cmd_ff.list_from <= LIST_FREE;
               cmd_age_ff       <= '0;
               ret_ff           <= S_TAKE_MV;
               st_ff            <= S_WAIT;
            end
            S_TAKE_MV: begin
               cmd_ff.op         <= OP_MOVE;
               cmd_ff.list_from  <= LIST_FREE;
               cmd_ff.list_to    <= LIST_T1;
               cmd_ff.write_key  <= 1'b1;
               cmd_key_ff        <= key_ff;
               cmd_age_ff        <= red_age;
               cnt_ff[LIST_FREE] <= cnt_ff[LIST_FREE] - CW'(1);
               cnt_ff[LIST_T1]   <= cnt_ff[LIST_T1] + CW'(1);
               ret_ff            <= S_OUT;
               st_ff             <= S_WAIT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_ev_ff     <= ev_ff;
                  rsp_ek_ff     <= EVKEY_W'(ek_ff);
                  st_ff         <= S_IDLE;
               end
            end
            default: begin
               st_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready       = (st_ff == S_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.evict_valid = rsp_ev_ff;
   assign rsp_chan.evict_key   = rsp_ek_ff;

endmodule

@@ rtl/core/arc_cell.sv @@
`timescale 1ns / 1ps

module arc_cell
   import arc_pkg::*;
#(
   parameter int KW    = 32,
   parameter int AW    = 7,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic [KW-1:0] cmd_key,
   input  logic [AW-1:0] cmd_age,
   output logic          sel,
   output logic [2:0]    list,
   output logic [AW-1:0] age,
   output logic [KW-1:0] key
);

   logic [KW-1:0] key_ff;
   logic [2:0]    list_ff;
   logic [AW-1:0] age_ff;
   logic          sel_ff;
   logic          match_key;
   logic          match_pick;
   logic          age_inc;
   logic          age_dec;

   // Local compares against the broadcast operation.
   always_comb begin
      match_key  = (list_ff != LIST_FREE) && (key_ff == cmd_key);
      match_pick = (list_ff == cmd.list_from) && (age_ff == cmd_age);
      age_inc    = (list_ff == cmd.list_to);
      age_dec    = (list_ff == cmd.list_from) && (age_ff > cmd_age);
   end

   // The key is payload and needs no reset.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_MOVE && sel_ff && cmd.write_key) begin
         key_ff <= cmd_key;
      end
   end

   // List, age and selection flag. After reset every cell sits on the free list.
   always_ff @(posedge clock) begin
      if (reset) begin
         list_ff <= LIST_FREE;
         age_ff  <= AW'(INDEX);
         sel_ff  <= 1'b0;
      end else begin
         case (cmd.op)
            OP_FIND: begin
               sel_ff <= match_key;
            end
            OP_PICK: begin
               sel_ff <= match_pick;
            end
            OP_MOVE: begin
               if (sel_ff) begin
                  list_ff <= cmd.list_to;
                  age_ff  <= '0;
               end else if (age_inc && !age_dec) begin
                  age_ff <= age_ff + AW'(1);
               end else if (age_dec && !age_inc) begin
                  age_ff <= age_ff - AW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign sel  = sel_ff;
   assign list = list_ff;
   assign age  = age_ff;
   assign key  = key_ff;

endmodule

@@ rtl/core/arc_cell_array.sv @@
`timescale 1ns / 1ps

module arc_cell_array
   import arc_pkg::*;
#(
   parameter int SLOTS = 128,
   parameter int KW    = 32,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic [KW-1:0] cmd_key,
   input  logic [AW-1:0] cmd_age,
   output logic          red_hit,
   output logic [2:0]    red_list,
   output logic [AW-1:0] red_age,
   output logic [KW-1:0] red_key
);

   logic [SLOTS-1:0] sel_w;
   logic [2:0]       list_w [SLOTS];
   logic [AW-1:0]    age_w  [SLOTS];
   logic [KW-1:0]    key_w  [SLOTS];

   // Row of directory cells, alike but for their INDEX.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      arc_cell #(
         .KW    (KW),
         .AW    (AW),
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .cmd_key (cmd_key),
         .cmd_age (cmd_age),
         .sel     (sel_w[i]),
         .list    (list_w[i]),
         .age     (age_w[i]),
         .key     (key_w[i])
      );
   end

   // At most one cell is selected, so its fields are gathered by an OR.
   always_comb begin
      red_hit  = 1'b0;
      red_list = '0;
      red_age  = '0;
      red_key  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         red_hit  = red_hit | sel_w[i];
         red_list = red_list | (sel_w[i] ? list_w[i] : 3'd0);
         red_age  = red_age | (sel_w[i] ? age_w[i] : '0);
         red_key  = red_key | (sel_w[i] ? key_w[i] : '0);
      end
   end

endmodule

@@ rtl/core/arc_div.sv @@
`timescale 1ns / 1ps

module arc_div
   import arc_pkg::*;
#(
   parameter int NW    = 8,
   parameter int FRAC  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NW-1:0]      num,
   input  logic [NW-1:0]      den,
   output logic               done,
   output logic [NW+FRAC-1:0] quo
);

   localparam int QW = NW + FRAC;
   localparam int NCW = $clog2(QW + 1);

   logic [QW-1:0]  dvd_ff;
   logic [QW-1:0]  quo_ff;
   logic [NW-1:0]  rem_ff;
   logic [NW-1:0]  den_ff;
   logic [NCW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [NW:0]    rem_sh;
   logic           fits;

   // One restoring step per cycle.
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[QW-1]};
      fits   = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= NCW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - NCW'(1);
            if (cnt_ff == NCW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {num, {FRAC{1'b0}}};
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[QW-2:0], 1'b0};
         quo_ff <= {quo_ff[QW-2:0], fits};
         rem_ff <= fits ? NW'(rem_sh - {1'b0, den_ff}) : NW'(rem_sh);
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ rtl/core/arc_checker.sv @@
`timescale 1ns / 1ps

module arc_checker
   import arc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_evict_valid,
   input logic [EVKEY_W-1:0]  rsp_evict_key
);

   // No response is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its transaction.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_evict_valid) && $stable(rsp_evict_key))
      else $error("stalled response changed");

   // Only defined status codes are reported.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_PUT_B2)
      else $error("undefined status code");

   // Without an eviction the key reads as zero.
   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evict_valid |-> rsp_evict_key == '0)
      else $error("evict key set without eviction");

   // Hits and get misses never evict.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_HIT_T1 || rsp_status == STATUS_HIT_T2
         || rsp_status == STATUS_GET_MISS) |-> !rsp_evict_valid)
      else $error("eviction reported on a hit or get miss");

endmodule

bind arc_replacement_policy arc_checker u_arc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_evict_valid (rsp_chan.evict_valid),
   .rsp_evict_key   (rsp_chan.evict_key)
);
